>>> hw/rtl/brf_pkg.sv
package brf_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NUM_VIS  = 16;
  localparam int unsigned NUM_FIQ  = 7;
  localparam int unsigned NUM_PRIV = 8;

  localparam logic [3:0] PC_IDX       = 4'd15;
  localparam logic [3:0] FIQ_FIRST    = 4'd8;
  localparam logic [3:0] PRIV_FIRST   = 4'd13;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  typedef enum logic [2:0] {
    CMD_READ      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_USER      = 3'd2,
    CMD_SET_PC    = 3'd3,
    CMD_SET_THUMB = 3'd4,
    CMD_MODE      = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [3:0]      reg_index;
    logic [XLEN-1:0] data_value;
    logic            write_enable;
  } req_t;

  typedef struct packed {
    logic [XLEN-1:0] read_data;
    logic            thumb_state;
    logic [4:0]      mode_state;
    logic            mode_unsupported;
  } res_t;

  function automatic logic mode_known(logic [4:0] m);
    return (m == MODE_USR) || (m == MODE_FIQ) || (m == MODE_IRQ) || (m == MODE_SVC) ||
           (m == MODE_ABT) || (m == MODE_UND) || (m == MODE_SYS);
  endfunction

  // Selects the r13/r14 pair of a privileged mode; bit 2 flags a mode with a pair.
  function automatic logic [2:0] priv_bank(logic [4:0] m);
    logic [2:0] b;
    unique case (m)
      MODE_ABT: b = 3'b100;
      MODE_IRQ: b = 3'b101;
      MODE_SVC: b = 3'b110;
      MODE_UND: b = 3'b111;
      default:  b = 3'b000;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/banked_register_file.sv
// Banked register file of an ARM-style core for the 32-bit modes. Each input transaction
// carries one command (read, write, user-bank access, set PC with interworking, set Thumb,
// mode switch) and yields exactly one result transaction holding the value read, the Thumb
// bit, the mode field and a flag for modes without a bank mapping. FIQ r8-r14 and the
// r13-r14 pairs of Abort, IRQ, Supervisor and Undefined are selected directly by the
// current mode, so a mode switch copies nothing. One transaction is accepted every cycle
// when the result side keeps up. An accepted command waits in the input register, executes
// once the result register can take its result, and its result is captured in the result
// register and offered on the output from there. When a result waits and the input
// register is full, the input side stalls until the result is taken. Each command executes
// as one combinational step against the flip-flop register banks.
module banked_register_file (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] cmd, [6:3] reg_index, [38:7] data_value, [39] write_enable
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_data, [32] thumb_state, [37:33] mode_state, [38] mode_unsupported,
  // [39] zero
  output logic [39:0] m_axis_tdata
);
  import brf_pkg::*;

  logic in_valid_q, in_valid_d;
  req_t in_req_q;
  logic out_valid_q, out_valid_d;
  res_t out_res_q;
  res_t res;
  logic advance;
  logic s_accept;

  // The command in the input register executes once the result register can take its
  // result, so the state always moves forward in acceptance order.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_req_q.cmd          <= s_axis_tdata[2:0];
      in_req_q.reg_index    <= s_axis_tdata[6:3];
      in_req_q.data_value   <= s_axis_tdata[38:7];
      in_req_q.write_enable <= s_axis_tdata[39];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  brf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (advance),
    .req_i  (in_req_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.mode_unsupported, out_res_q.mode_state,
                          out_res_q.thumb_state, out_res_q.read_data};

endmodule

>>> hw/rtl/brf_core.sv
module brf_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          exec_i,
  input  brf_pkg::req_t req_i,
  output brf_pkg::res_t res_o
);
  import brf_pkg::*;

  logic [XLEN-1:0] vis_q  [NUM_VIS];
  logic [XLEN-1:0] vis_d  [NUM_VIS];
  logic [XLEN-1:0] fiq_q  [NUM_FIQ];
  logic [XLEN-1:0] fiq_d  [NUM_FIQ];
  logic [XLEN-1:0] priv_q [NUM_PRIV];
  logic [XLEN-1:0] priv_d [NUM_PRIV];
  logic [4:0]      mode_q, mode_d;
  logic            thumb_q, thumb_d;

  logic [3:0]      r;
  logic [2:0]      bank;
  logic [2:0]      priv_idx;
  logic            use_fiq, use_priv;
  logic [XLEN-1:0] pc;
  logic [XLEN-1:0] pc_view;
  logic [XLEN-1:0] phys_rd;
  logic [XLEN-1:0] rd;
  logic            unsup;

  assign r        = req_i.reg_index;
  assign bank     = priv_bank(mode_q);
  assign priv_idx = {bank[1:0], r[1]};
  assign use_fiq  = (mode_q == MODE_FIQ) && (r >= FIQ_FIRST) && (r != PC_IDX);
  assign use_priv = bank[2] && (r >= PRIV_FIRST) && (r != PC_IDX);
  assign pc       = vis_q[PC_IDX];
  assign pc_view  = thumb_q ? ({pc[XLEN-1:1], 1'b0} + XLEN'(2))
                            : ({pc[XLEN-1:2], 2'b00} + XLEN'(4));

  always_comb begin
    if (use_fiq) begin
      phys_rd = fiq_q[r[2:0]];
    end else if (use_priv) begin
      phys_rd = priv_q[priv_idx];
    end else begin
      phys_rd = vis_q[r];
    end
  end

  always_comb begin
    vis_d   = vis_q;
    fiq_d   = fiq_q;
    priv_d  = priv_q;
    mode_d  = mode_q;
    thumb_d = thumb_q;
    rd      = '0;
    unsup   = 1'b0;
    unique case (req_i.cmd)
      CMD_READ: begin
        rd = (r == PC_IDX) ? pc_view : phys_rd;
      end
      CMD_WRITE: begin
        if (use_fiq) begin
          fiq_d[r[2:0]] = req_i.data_value;
        end else if (use_priv) begin
          priv_d[priv_idx] = req_i.data_value;
        end else begin
          vis_d[r] = req_i.data_value;
        end
      end
      CMD_USER: begin
        rd = (r == PC_IDX) ? pc_view : vis_q[r];
        if (req_i.write_enable) begin
          vis_d[r] = req_i.data_value;
        end
      end
      CMD_SET_PC: begin
        thumb_d = req_i.data_value[0];
        vis_d[PC_IDX] = req_i.data_value[0] ? {req_i.data_value[XLEN-1:1], 1'b0}
                                            : {req_i.data_value[XLEN-1:2], 2'b00};
      end
      CMD_SET_THUMB: begin
        thumb_d = req_i.data_value[0];
        vis_d[PC_IDX] = req_i.data_value[0] ? {pc[XLEN-1:1], 1'b0}
                                            : {pc[XLEN-1:2], 2'b00};
      end
      CMD_MODE: begin
        mode_d = req_i.data_value[4:0];
        unsup  = !mode_known(mode_q) || !mode_known(req_i.data_value[4:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VIS; i++) vis_q[i] <= '0;
      for (int i = 0; i < NUM_FIQ; i++) fiq_q[i] <= '0;
      for (int i = 0; i < NUM_PRIV; i++) priv_q[i] <= '0;
      mode_q  <= MODE_SVC;
      thumb_q <= 1'b0;
    end else if (exec_i) begin
      vis_q   <= vis_d;
      fiq_q   <= fiq_d;
      priv_q  <= priv_d;
      mode_q  <= mode_d;
      thumb_q <= thumb_d;
    end
  end

  assign res_o.read_data        = rd;
  assign res_o.thumb_state      = thumb_d;
  assign res_o.mode_state       = mode_d;
  assign res_o.mode_unsupported = unsup;

endmodule

>>> hw/rtl/brf_checker.sv
module brf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // The input side only stalls behind a result that is waiting to be taken.
  a_stall_only_behind_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting result");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[39])
    else $error("result padding bit set");

endmodule

bind banked_register_file brf_checker u_brf_checker (.*);
